### sv/oledc_pkg.sv
// ----------------------------------------------------------------------------
// oledc_pkg
// Shared types, command codes and constants of the OLED page RAM controller.
// ----------------------------------------------------------------------------
package oledc_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_SCAN = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PANEL_HEIGHT = 3'd0,
    CFG_COM_OFFSET   = 3'd1,
    CFG_SEG_OFFSET   = 3'd2,
    CFG_COL_START    = 3'd3,
    CFG_COL_END      = 3'd4,
    CFG_PAGE_START   = 3'd5,
    CFG_PAGE_END     = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // command codes
  localparam logic [7:0] OP_MODE_PAGE     = 8'h20;
  localparam logic [7:0] OP_MODE_COLUMN   = 8'h21;
  localparam logic [7:0] OP_REMAP_OFF     = 8'hA0;
  localparam logic [7:0] OP_REMAP_ON      = 8'hA1;
  localparam logic [7:0] OP_ALL_ON_OFF    = 8'hA4;
  localparam logic [7:0] OP_ALL_ON        = 8'hA5;
  localparam logic [7:0] OP_NORMAL        = 8'hA6;
  localparam logic [7:0] OP_INVERSE       = 8'hA7;
  localparam logic [7:0] OP_MUX_RATIO     = 8'hA8;
  localparam logic [7:0] OP_DISPLAY_OFF   = 8'hAE;
  localparam logic [7:0] OP_DISPLAY_ON    = 8'hAF;
  localparam logic [7:0] OP_ROW_OFFSET    = 8'hD3;
  localparam logic [7:0] OP_START_LINE    = 8'hDC;
  localparam logic [7:0] OP_CONTRAST      = 8'h81;
  localparam logic [7:0] OP_CLOCK_DIV     = 8'hD5;
  localparam logic [7:0] OP_PRECHARGE     = 8'hD9;
  localparam logic [7:0] OP_DCDC          = 8'hAD;
  localparam logic [7:0] OP_VCOM          = 8'hDB;
  localparam logic [7:0] OP_COL_LO_FIRST  = 8'h00;
  localparam logic [7:0] OP_COL_LO_LAST   = 8'h0F;
  localparam logic [7:0] OP_COL_HI_FIRST  = 8'h10;
  localparam logic [7:0] OP_COL_HI_LAST   = 8'h17;
  localparam logic [7:0] OP_PAGE_FIRST    = 8'hB0;
  localparam logic [7:0] OP_PAGE_LAST     = 8'hBF;
  localparam logic [7:0] OP_COM_DIR_FIRST = 8'hC0;
  localparam logic [7:0] OP_COM_DIR_LAST  = 8'hCF;
  localparam logic [7:0] OP_NONE          = 8'h00;

  // show modes; bit 1 set means all pixels on
  localparam logic [1:0] SHOW_NORMAL  = 2'd0;
  localparam logic [1:0] SHOW_INVERSE = 2'd1;

  localparam logic [15:0] LIT_COLOR = 16'hAD59;
  localparam logic [7:0]  COL_MAX   = 8'h7F;
  localparam logic [4:0]  PAGE_MAX  = 5'h0F;

  typedef struct packed {
    logic [7:0] panel_height;
    logic [6:0] com_offset;
    logic [6:0] seg_offset;
    logic [6:0] col_start;
    logic [6:0] col_end;
    logic [3:0] page_start;
    logic [3:0] page_end;
  } cfg_t;

  // settings a scan needs
  typedef struct packed {
    logic       seg_remap;
    logic       scan_reverse;
    logic [7:0] start_line;
    logic [7:0] row_offset;
    logic [7:0] mux_ratio;
    logic       panel_enabled;
    logic [1:0] show_mode;
  } ctrl_t;

  function automatic logic takes_argument(logic [7:0] op);
    return (op == OP_MUX_RATIO) || (op == OP_ROW_OFFSET) || (op == OP_START_LINE) ||
           (op == OP_CONTRAST) || (op == OP_CLOCK_DIV) || (op == OP_PRECHARGE) ||
           (op == OP_DCDC) || (op == OP_VCOM);
  endfunction

endpackage

### sv/oledc_in_if.sv
// ----------------------------------------------------------------------------
// oledc_in_if
// Input channel: command, data or scan word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface oledc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [6:0] pixel_x;
  logic [6:0] pixel_y;

  modport source (output valid, kind, byte_value, pixel_x, pixel_y, input ready);
  modport sink   (input valid, kind, byte_value, pixel_x, pixel_y, output ready);
endinterface

### sv/oledc_out_if.sv
// ----------------------------------------------------------------------------
// oledc_out_if
// Result channel: one result word per input word.
// ----------------------------------------------------------------------------
interface oledc_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_lit;
  logic [15:0] pixel_color;
  logic        redraw_needed;

  modport source (output valid, pixel_lit, pixel_color, redraw_needed, input ready);
  modport sink   (input valid, pixel_lit, pixel_color, redraw_needed, output ready);
endinterface

### sv/oledc_ram.sv
// ----------------------------------------------------------------------------
// oledc_ram
// Display RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oledc_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/oledc_regs.sv
// ----------------------------------------------------------------------------
// oledc_regs
// Configuration registers, command decoder and address pointer.
// ----------------------------------------------------------------------------
module oledc_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [oledc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [oledc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                               accept_i,
  input  oledc_pkg::kind_e                   kind_i,
  input  logic [7:0]                         byte_i,
  output oledc_pkg::cfg_t                    cfg_o,
  output oledc_pkg::ctrl_t                   ctrl_o,
  output logic [6:0]                         cur_col_o,
  output logic [3:0]                         cur_page_o,
  output logic                               redraw_o
);

  oledc_pkg::cfg_t  cfg_q, cfg_d;
  oledc_pkg::ctrl_t ctrl_q, ctrl_d;
  logic [6:0] col_q, col_d;
  logic [3:0] page_q, page_d;
  logic       page_mode_q, page_mode_d;
  logic       pend_q, pend_d;
  logic [7:0] op_q, op_d;
  logic [7:0] next_col;
  logic [4:0] next_page;

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (oledc_pkg::cfg_idx_e'(cfg_index_i))
        oledc_pkg::CFG_PANEL_HEIGHT: cfg_d.panel_height = cfg_wdata_i;
        oledc_pkg::CFG_COM_OFFSET:   cfg_d.com_offset   = cfg_wdata_i[6:0];
        oledc_pkg::CFG_SEG_OFFSET:   cfg_d.seg_offset   = cfg_wdata_i[6:0];
        oledc_pkg::CFG_COL_START:    cfg_d.col_start    = cfg_wdata_i[6:0];
        oledc_pkg::CFG_COL_END:      cfg_d.col_end      = cfg_wdata_i[6:0];
        oledc_pkg::CFG_PAGE_START:   cfg_d.page_start   = cfg_wdata_i[3:0];
        oledc_pkg::CFG_PAGE_END:     cfg_d.page_end     = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign next_col  = {1'b0, col_q} + 8'd1;
  assign next_page = {1'b0, page_q} + 5'd1;

  // command decode and pointer advance
  always_comb begin
    ctrl_d      = ctrl_q;
    col_d       = col_q;
    page_d      = page_q;
    page_mode_d = page_mode_q;
    pend_d      = pend_q;
    op_d        = op_q;
    redraw_o    = 1'b0;
    if (accept_i) begin
      case (kind_i)
        oledc_pkg::KIND_CMD: begin
          if (pend_q) begin
            pend_d = 1'b0;
            op_d   = oledc_pkg::OP_NONE;
            case (op_q)
              oledc_pkg::OP_MUX_RATIO: begin
                ctrl_d.mux_ratio = byte_i;
                redraw_o         = ctrl_q.panel_enabled;
              end
              oledc_pkg::OP_ROW_OFFSET: begin
                ctrl_d.row_offset = byte_i;
                redraw_o          = ctrl_q.panel_enabled;
              end
              oledc_pkg::OP_START_LINE: begin
                ctrl_d.start_line = byte_i;
                redraw_o          = ctrl_q.panel_enabled;
              end
              default: ;
            endcase
          end else if (oledc_pkg::takes_argument(byte_i)) begin
            pend_d = 1'b1;
            op_d   = byte_i;
          end else begin
            case (byte_i) inside
              oledc_pkg::OP_MODE_PAGE:   page_mode_d = 1'b1;
              oledc_pkg::OP_MODE_COLUMN: page_mode_d = 1'b0;
              oledc_pkg::OP_REMAP_OFF:   ctrl_d.seg_remap = 1'b0;
              oledc_pkg::OP_REMAP_ON:    ctrl_d.seg_remap = 1'b1;
              oledc_pkg::OP_ALL_ON_OFF: begin
                ctrl_d.show_mode = {1'b0, ctrl_q.show_mode[0]};
                redraw_o         = ctrl_q.panel_enabled;
              end
              oledc_pkg::OP_ALL_ON: begin
                ctrl_d.show_mode = {1'b1, ctrl_q.show_mode[0]};
                redraw_o         = ctrl_q.panel_enabled;
              end
              oledc_pkg::OP_NORMAL: begin
                ctrl_d.show_mode = oledc_pkg::SHOW_NORMAL;
                redraw_o         = ctrl_q.panel_enabled;
              end
              oledc_pkg::OP_INVERSE: begin
                ctrl_d.show_mode = oledc_pkg::SHOW_INVERSE;
                redraw_o         = ctrl_q.panel_enabled;
              end
              oledc_pkg::OP_DISPLAY_OFF: begin
                ctrl_d.panel_enabled = 1'b0;
                redraw_o             = 1'b1;
              end
              oledc_pkg::OP_DISPLAY_ON: begin
                ctrl_d.panel_enabled = 1'b1;
                redraw_o             = 1'b1;
              end
              [oledc_pkg::OP_COM_DIR_FIRST:oledc_pkg::OP_COM_DIR_LAST]: begin
                ctrl_d.scan_reverse = byte_i[3];
                redraw_o            = ctrl_q.panel_enabled;
              end
              [oledc_pkg::OP_PAGE_FIRST:oledc_pkg::OP_PAGE_LAST]: page_d = byte_i[3:0];
              [oledc_pkg::OP_COL_LO_FIRST:oledc_pkg::OP_COL_LO_LAST]:
                col_d = {col_q[6:4], byte_i[3:0]};
              [oledc_pkg::OP_COL_HI_FIRST:oledc_pkg::OP_COL_HI_LAST]:
                col_d = {byte_i[2:0], col_q[3:0]};
              default: ;
            endcase
          end
        end
        oledc_pkg::KIND_DATA: begin
          redraw_o = 1'b1;
          if (page_mode_q) begin
            if (next_col > {1'b0, cfg_q.col_end} || next_col > oledc_pkg::COL_MAX) begin
              col_d = cfg_q.col_start;
            end else begin
              col_d = next_col[6:0];
            end
          end else begin
            if (next_page > {1'b0, cfg_q.page_end} || next_page > oledc_pkg::PAGE_MAX) begin
              page_d = cfg_q.page_start;
            end else begin
              page_d = next_page[3:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.panel_height   <= 8'd64;
      cfg_q.com_offset     <= 7'd0;
      cfg_q.seg_offset     <= 7'd0;
      cfg_q.col_start      <= 7'd0;
      cfg_q.col_end        <= 7'd127;
      cfg_q.page_start     <= 4'd0;
      cfg_q.page_end       <= 4'd7;
      ctrl_q.seg_remap     <= 1'b0;
      ctrl_q.scan_reverse  <= 1'b0;
      ctrl_q.start_line    <= 8'd0;
      ctrl_q.row_offset    <= 8'd0;
      ctrl_q.mux_ratio     <= 8'd15;
      ctrl_q.panel_enabled <= 1'b0;
      ctrl_q.show_mode     <= oledc_pkg::SHOW_NORMAL;
      col_q                <= 7'd0;
      page_q               <= 4'd0;
      page_mode_q          <= 1'b1;
      pend_q               <= 1'b0;
      op_q                 <= oledc_pkg::OP_NONE;
    end else begin
      cfg_q       <= cfg_d;
      ctrl_q      <= ctrl_d;
      col_q       <= col_d;
      page_q      <= page_d;
      page_mode_q <= page_mode_d;
      pend_q      <= pend_d;
      op_q        <= op_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign ctrl_o     = ctrl_q;
  assign cur_col_o  = col_q;
  assign cur_page_o = page_q;

endmodule

### sv/oled_controller_ram_and_scan.sv
// ----------------------------------------------------------------------------
// oled_controller_ram_and_scan
// Monochrome OLED controller: page RAM, command decoder and pixel scan-out.
// ----------------------------------------------------------------------------
//
// Channel   | Dir | Handshake     | Word
// ----------+-----+---------------+-----------------------------------------
// item_i    | in  | valid/ready   | kind, byte_value, pixel_x, pixel_y
// result_o  | out | valid/ready   | pixel_lit, pixel_color, redraw_needed
// cfg_*     | in  | write enable  | cfg_index_i, cfg_wdata_i (no read-back)
//
// One word per clock sustained while result_o does not stall; each word passes
// stage 1 (RAM write/read) and then stage 2 (the output register) before it leaves.
// The single RAM port pair is what paces it: the write of a data word and
// the read of a scan word both happen in stage 1, in arrival order.
// After reset the RAM is cleared one entry per clock (RAM_COLUMNS*RAM_PAGES
// entries, 2048 by default); item_i.ready stays low until then, config
// writes are taken throughout.
// A stall on result_o freezes both stages and the RAM read data.
// ----------------------------------------------------------------------------
module oled_controller_ram_and_scan #(
  parameter int unsigned RAM_COLUMNS = 128,
  parameter int unsigned RAM_PAGES   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [oledc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [oledc_pkg::CfgDataW-1:0] cfg_wdata_i,
  oledc_in_if.sink                       item_i,
  oledc_out_if.source                    result_o
);

  localparam int unsigned Depth = RAM_COLUMNS * RAM_PAGES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [7:0]       ColsW  = 8'(RAM_COLUMNS);
  localparam logic [4:0]       PagesW = 5'(RAM_PAGES);
  localparam logic [AddrW-1:0] PagesA = AddrW'(RAM_PAGES);
  localparam logic [AddrW-1:0] LastA  = AddrW'(Depth - 1);

  // column and page fold into the RAM, then row-major by column
  function automatic logic [AddrW-1:0] ram_index(logic [6:0] col, logic [3:0] page);
    logic [7:0] c;
    logic [4:0] p;
    c = {1'b0, col};
    p = {1'b0, page};
    if (c >= ColsW) c = c - ColsW;
    if (p >= PagesW) p = p - PagesW;
    return AddrW'(c) * PagesA + AddrW'(p);
  endfunction

  oledc_pkg::cfg_t  cfg;
  oledc_pkg::ctrl_t ctrl;
  oledc_pkg::kind_e in_kind;
  logic [6:0] cur_col;
  logic [3:0] cur_page;
  logic       redraw;
  logic       adv;
  logic       accept;

  // clearing pass
  logic             clearing_q;
  logic [AddrW-1:0] clr_q;

  // stage 1
  logic             s1_valid_q;
  oledc_pkg::kind_e s1_kind_q;
  logic             s1_redraw_q;
  logic [AddrW-1:0] s1_waddr_q;
  logic [7:0]       s1_wdata_q;
  logic [6:0]       s1_col_q;
  logic [7:0]       s1_base_q;
  oledc_pkg::ctrl_t s1_ctrl_q;

  // stage 2 / output register
  logic             s2_valid_q;
  logic             s2_scan_q;
  logic             s2_redraw_q;
  logic [2:0]       s2_bit_q;
  logic             s2_beyond_q;
  logic [1:0]       s2_show_q;
  logic             s2_en_q;

  // front-end scan mapping
  logic [6:0] com, seg, col0;
  logic [7:0] base0;

  // stage 1 scan mapping
  logic [7:0]       row, ram_row, row_wrap;
  logic             beyond;
  logic [AddrW-1:0] raddr;

  // RAM ports
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata, ram_rdata;

  // output
  logic        pix_bit;
  logic [15:0] color;

  // the whole pipe moves when the output register is free or drained
  assign adv     = !s2_valid_q || result_o.ready;
  assign item_i.ready = adv && !clearing_q;
  assign accept  = item_i.valid && item_i.ready;
  assign in_kind = oledc_pkg::kind_e'(item_i.kind);

  oledc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .kind_i      (in_kind),
    .byte_i      (item_i.byte_value),
    .cfg_o       (cfg),
    .ctrl_o      (ctrl),
    .cur_col_o   (cur_col),
    .cur_page_o  (cur_page),
    .redraw_o    (redraw)
  );

  // wiring offsets, column direction and segment remap
  assign com   = item_i.pixel_x + cfg.com_offset;
  assign seg   = item_i.pixel_y + cfg.seg_offset;
  assign col0  = ctrl.scan_reverse ? com : ~com;
  assign base0 = ctrl.seg_remap ? {1'b0, seg} : ctrl.mux_ratio - {1'b0, seg};

  // row offset, start line, panel wrap, mux limit
  always_comb begin
    row      = s1_base_q + s1_ctrl_q.row_offset;
    ram_row  = {1'b0, (row[6:0] + s1_ctrl_q.start_line[6:0])};
    row_wrap = (row >= cfg.panel_height) ? row - cfg.panel_height : row;
    beyond   = row_wrap >= s1_ctrl_q.mux_ratio;
    raddr    = ram_index(s1_col_q, ram_row[6:3]);
  end

  // RAM: clear sweep owns the write port until done
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_waddr_q;
    ram_wdata = s1_wdata_q;
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = 8'h00;
    end else if (adv && s1_valid_q && s1_kind_q == oledc_pkg::KIND_DATA) begin
      ram_we = 1'b1;
    end
  end
  assign ram_re = adv && s1_valid_q && s1_kind_q == oledc_pkg::KIND_SCAN;

  oledc_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == LastA) begin
          clearing_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_q <= accept;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q   <= in_kind;
      s1_redraw_q <= redraw;
      s1_waddr_q  <= ram_index(cur_col, cur_page);
      s1_wdata_q  <= item_i.byte_value;
      s1_col_q    <= col0;
      s1_base_q   <= base0;
      s1_ctrl_q   <= ctrl;
    end
    if (adv && s1_valid_q) begin
      s2_scan_q   <= s1_kind_q == oledc_pkg::KIND_SCAN;
      s2_redraw_q <= s1_redraw_q;
      s2_bit_q    <= ram_row[2:0];
      s2_beyond_q <= beyond;
      s2_show_q   <= s1_ctrl_q.show_mode;
      s2_en_q     <= s1_ctrl_q.panel_enabled;
    end
  end

  // pixel color from the registered RAM byte
  always_comb begin
    pix_bit = ram_rdata[s2_bit_q] && !s2_beyond_q;
    case (s2_show_q)
      oledc_pkg::SHOW_NORMAL:  color = pix_bit ? oledc_pkg::LIT_COLOR : 16'h0000;
      oledc_pkg::SHOW_INVERSE: color = pix_bit ? 16'h0000 : oledc_pkg::LIT_COLOR;
      default:                 color = oledc_pkg::LIT_COLOR;
    endcase
    if (!s2_en_q || !s2_scan_q) color = 16'h0000;
  end

  assign result_o.valid         = s2_valid_q;
  assign result_o.pixel_color   = color;
  assign result_o.pixel_lit     = color != 16'h0000;
  assign result_o.redraw_needed = s2_redraw_q;

endmodule

### sv/oledc_checker.sv
// ----------------------------------------------------------------------------
// oledc_checker
// Port-level checks on the result channel and the post-reset clear.
// ----------------------------------------------------------------------------
module oledc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_ready_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        pixel_lit_i,
  input  logic [15:0] pixel_color_i,
  input  logic        redraw_i
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_color_i) &&
    $stable(pixel_lit_i) && $stable(redraw_i))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pixel_color_i == 16'h0000 || pixel_color_i == oledc_pkg::LIT_COLOR)
    else $error("pixel color outside palette");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pixel_lit_i == (pixel_color_i != 16'h0000))
    else $error("lit flag disagrees with color");

  // scan words never request redraw, others never light
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && redraw_i |-> !pixel_lit_i)
    else $error("redraw and lit pixel in one word");

  // RAM clear keeps the input closed right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input ready during RAM clear");

endmodule

bind oled_controller_ram_and_scan oledc_checker u_oledc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .pixel_lit_i   (result_o.pixel_lit),
  .pixel_color_i (result_o.pixel_color),
  .redraw_i      (result_o.redraw_needed)
);

### bench/oled_controller_ram_and_scan_tb.sv
// ----------------------------------------------------------------------------
// oled_controller_ram_and_scan_tb
// Self-checking bench for the OLED page RAM controller and pixel scan-out.
// Words of commands, display data and pixel scans go in through a bursty
// sender. A shadow of the controller state predicts every result word, and
// a stalling receiver checks the results in order. The run is split into
// phases with different panel and window settings, written while idle.
// ----------------------------------------------------------------------------
module oled_controller_ram_and_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oledc_pkg::*;

  localparam int unsigned QUIET_LIMIT      = 6000;  // covers the RAM clear after reset
  localparam int unsigned REPORT_MAX       = 10;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam int unsigned RAM_WORDS        = 2048;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    logic [6:0] pixel_x;
    logic [6:0] pixel_y;
  } panel_word_t;

  typedef struct packed {
    logic        lit;
    logic [15:0] color;
    logic        redraw;
  } pixel_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  oledc_in_if  item_if ();
  oledc_out_if result_if ();

  oled_controller_ram_and_scan u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  // --------------------------------------------------------------------------
  // Shadow of the controller state, advanced once per accepted input word
  // --------------------------------------------------------------------------
  logic [7:0] shadow_ram [RAM_WORDS];
  cfg_t       shadow_cfg;
  ctrl_t      shadow_ctl;
  logic [6:0] shadow_col;
  logic [3:0] shadow_page;
  logic       shadow_page_mode;
  logic [7:0] held_op;      // command waiting for its argument byte
  logic       op_held;

  // queues: words still to send, results still to come back
  panel_word_t   panel_word_q[$];
  pixel_result_t pixel_expect_q[$];

  int unsigned queued_cnt;
  int unsigned result_cnt;
  int unsigned fault_cnt;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_tick;
  int unsigned stall_mode;
  panel_word_t next_word;

  // Works out the result word of one input word and updates the shadow.
  function automatic pixel_result_t oled_response(input logic [1:0] kind,
                                                  input logic [7:0] value,
                                                  input logic [6:0] px,
                                                  input logic [6:0] py);
    pixel_result_t res;
    logic [6:0]    com;
    logic [6:0]    seg;
    logic [6:0]    col;
    logic [7:0]    base;
    logic [7:0]    row;
    logic [7:0]    ram_row;
    logic          dot;
    logic [7:0]    nxt_col;
    logic [4:0]    nxt_page;
    res = '0;
    if (kind == KIND_CMD) begin
      if (op_held) begin
        // argument byte: only three of the held commands keep it
        if (held_op == OP_MUX_RATIO) begin
          shadow_ctl.mux_ratio = value;
          res.redraw = shadow_ctl.panel_enabled;
        end else if (held_op == OP_ROW_OFFSET) begin
          shadow_ctl.row_offset = value;
          res.redraw = shadow_ctl.panel_enabled;
        end else if (held_op == OP_START_LINE) begin
          shadow_ctl.start_line = value;
          res.redraw = shadow_ctl.panel_enabled;
        end
        op_held = 1'b0;
        held_op = OP_NONE;
      end else begin
        case (value)
          OP_MUX_RATIO, OP_ROW_OFFSET, OP_START_LINE, OP_CONTRAST,
          OP_CLOCK_DIV, OP_PRECHARGE, OP_DCDC, OP_VCOM: begin
            held_op = value;
            op_held = 1'b1;
          end
          OP_MODE_PAGE:   shadow_page_mode = 1'b1;
          OP_MODE_COLUMN: shadow_page_mode = 1'b0;
          OP_REMAP_OFF:   shadow_ctl.seg_remap = 1'b0;
          OP_REMAP_ON:    shadow_ctl.seg_remap = 1'b1;
          OP_ALL_ON_OFF: begin
            shadow_ctl.show_mode[1] = 1'b0;
            res.redraw = shadow_ctl.panel_enabled;
          end
          OP_ALL_ON: begin
            shadow_ctl.show_mode[1] = 1'b1;
            res.redraw = shadow_ctl.panel_enabled;
          end
          OP_NORMAL: begin
            shadow_ctl.show_mode = SHOW_NORMAL;
            res.redraw = shadow_ctl.panel_enabled;
          end
          OP_INVERSE: begin
            shadow_ctl.show_mode = SHOW_INVERSE;
            res.redraw = shadow_ctl.panel_enabled;
          end
          OP_DISPLAY_OFF: begin
            shadow_ctl.panel_enabled = 1'b0;
            res.redraw = 1'b1;
          end
          OP_DISPLAY_ON: begin
            shadow_ctl.panel_enabled = 1'b1;
            res.redraw = 1'b1;
          end
          default: begin
            if (value >= OP_COM_DIR_FIRST && value <= OP_COM_DIR_LAST) begin
              shadow_ctl.scan_reverse = value[3];
              res.redraw = shadow_ctl.panel_enabled;
            end else if (value >= OP_PAGE_FIRST && value <= OP_PAGE_LAST) begin
              shadow_page = value[3:0];
            end else if (value <= OP_COL_LO_LAST) begin
              shadow_col[3:0] = value[3:0];
            end else if (value >= OP_COL_HI_FIRST && value <= OP_COL_HI_LAST) begin
              shadow_col[6:4] = value[2:0];
            end
          end
        endcase
      end
    end else if (kind == KIND_DATA) begin
      shadow_ram[{shadow_col, shadow_page}] = value;
      res.redraw = 1'b1;
      // address steps inside the window, wrapping back to the window start
      if (shadow_page_mode) begin
        nxt_col = {1'b0, shadow_col} + 8'd1;
        if (nxt_col > {1'b0, shadow_cfg.col_end} || nxt_col > COL_MAX)
          nxt_col = {1'b0, shadow_cfg.col_start};
        shadow_col = nxt_col[6:0];
      end else begin
        nxt_page = {1'b0, shadow_page} + 5'd1;
        if (nxt_page > {1'b0, shadow_cfg.page_end} || nxt_page > PAGE_MAX)
          nxt_page = {1'b0, shadow_cfg.page_start};
        shadow_page = nxt_page[3:0];
      end
    end else if (kind == KIND_SCAN) begin
      com     = px + shadow_cfg.com_offset;
      seg     = py + shadow_cfg.seg_offset;
      col     = shadow_ctl.scan_reverse ? com : ~com;
      base    = shadow_ctl.seg_remap ? {1'b0, seg} : shadow_ctl.mux_ratio - {1'b0, seg};
      row     = base + shadow_ctl.row_offset;
      // the RAM row is taken before the panel wrap; the wrap only gates mux
      ram_row = (row + shadow_ctl.start_line) & 8'h7F;
      if (row >= shadow_cfg.panel_height) row = row - shadow_cfg.panel_height;
      dot = shadow_ram[{col, ram_row[6:3]}][ram_row[2:0]];
      if (row >= shadow_ctl.mux_ratio) dot = 1'b0;
      if (shadow_ctl.show_mode[1]) res.color = LIT_COLOR;
      else if (shadow_ctl.show_mode == SHOW_INVERSE) res.color = dot ? 16'h0 : LIT_COLOR;
      else res.color = dot ? LIT_COLOR : 16'h0;
      if (!shadow_ctl.panel_enabled) res.color = 16'h0;
      res.lit = |res.color;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps; valid holds until taken.
  // The shadow advances on each accepted word.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid      <= 1'b0;
      item_if.kind       <= KIND_CMD;
      item_if.byte_value <= 8'h00;
      item_if.pixel_x    <= 7'd0;
      item_if.pixel_y    <= 7'd0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (item_if.valid && item_if.ready)
        pixel_expect_q.push_back(oled_response(item_if.kind, item_if.byte_value,
                                               item_if.pixel_x, item_if.pixel_y));
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (panel_word_q.size() != 0) begin
          next_word = panel_word_q.pop_front();
          item_if.valid      <= 1'b1;
          item_if.kind       <= next_word.kind;
          item_if.byte_value <= next_word.byte_value;
          item_if.pixel_x    <= next_word.pixel_x;
          item_if.pixel_y    <= next_word.pixel_y;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a zero gap lets bursts run together into long idle-free stretches
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn at random, periodically, among always
  // ready, ready dropped periodically, coin flip, and long stalls. Each taken word
  // is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_tick = 0;
      stall_mode = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (pixel_expect_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= REPORT_MAX)
            $display("result %0d with nothing expected: lit=%0b color=%h redraw=%0b",
                     result_cnt, result_if.pixel_lit, result_if.pixel_color,
                     result_if.redraw_needed);
        end else begin
          if (pixel_expect_q[0].lit !== result_if.pixel_lit ||
              pixel_expect_q[0].color !== result_if.pixel_color ||
              pixel_expect_q[0].redraw !== result_if.redraw_needed) begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
              $display("result %0d: expected lit=%0b color=%h redraw=%0b, got lit=%0b color=%h redraw=%0b",
                       result_cnt, pixel_expect_q[0].lit, pixel_expect_q[0].color,
                       pixel_expect_q[0].redraw, result_if.pixel_lit,
                       result_if.pixel_color, result_if.redraw_needed);
          end
          void'(pixel_expect_q.pop_front());
        end
        result_cnt++;
      end
      stall_tick++;
      if (stall_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= (stall_tick % 4) != 0;
        2:       result_if.ready <= 1'($urandom_range(0, 1));
        default: result_if.ready <= (stall_tick % 16) < 4;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no word taken on either side ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(input kind_e k, input logic [7:0] b,
                           input logic [6:0] x, input logic [6:0] y);
    panel_word_t w;
    w.kind       = k;
    w.byte_value = b;
    w.pixel_x    = x;
    w.pixel_y    = y;
    panel_word_q.push_back(w);
    queued_cnt++;
  endtask

  // command byte; pixel fields are don't-care, so keep them toggling
  task automatic push_op(input logic [7:0] op);
    push_word(KIND_CMD, op, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  task automatic push_scan();
    logic [6:0] x;
    logic [6:0] y;
    x = 7'($urandom_range(0, 127));
    y = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? 7'h7F : 7'h00;
    if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? 7'h7F : 7'h00;
    push_word(KIND_SCAN, 8'($urandom_range(0, 255)), x, y);
  endtask

  task automatic push_data();
    push_word(KIND_DATA, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
  endtask

  // two-byte command; now and then a data or scan word sits in between,
  // which must leave the argument pending
  task automatic push_with_arg(input logic [7:0] op, input logic [7:0] arg);
    push_op(op);
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) push_data();
      else push_scan();
    end
    push_op(arg);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
  endtask

  // only called while nothing is in flight
  task automatic program_panel(input int unsigned h, input int unsigned com_off,
                               input int unsigned seg_off, input int unsigned cs,
                               input int unsigned ce, input int unsigned ps,
                               input int unsigned pe);
    shadow_cfg.panel_height = 8'(h);
    shadow_cfg.com_offset   = 7'(com_off);
    shadow_cfg.seg_offset   = 7'(seg_off);
    shadow_cfg.col_start    = 7'(cs);
    shadow_cfg.col_end      = 7'(ce);
    shadow_cfg.page_start   = 4'(ps);
    shadow_cfg.page_end     = 4'(pe);
    write_reg(CFG_PANEL_HEIGHT, 8'(h));
    write_reg(CFG_COM_OFFSET, 8'(com_off));
    write_reg(CFG_SEG_OFFSET, 8'(seg_off));
    write_reg(CFG_COL_START, 8'(cs));
    write_reg(CFG_COL_END, 8'(ce));
    write_reg(CFG_PAGE_START, 8'(ps));
    write_reg(CFG_PAGE_END, 8'(pe));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // idle: nothing queued, nothing on the input bus, no result outstanding
  task automatic wait_drained();
    while (panel_word_q.size() != 0 || item_if.valid || pixel_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Mostly well-formed command traffic, data and scans; the rest is
  // arbitrary command bytes and words of the unused kind.
  task automatic push_random_traffic(input int unsigned n);
    int unsigned start;
    int unsigned sel;
    start = queued_cnt;
    while (queued_cnt - start < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        push_scan();
      end else if (sel < 55) begin
        push_data();
      end else if (sel < 88) begin
        case ($urandom_range(0, 11))
          0:  push_op($urandom_range(0, 1) ? OP_MODE_PAGE : OP_MODE_COLUMN);
          1:  push_op($urandom_range(0, 1) ? OP_REMAP_ON : OP_REMAP_OFF);
          2:  push_op(OP_ALL_ON_OFF + 8'($urandom_range(0, 3)));
          3:  push_op(($urandom_range(0, 5) == 0) ? OP_DISPLAY_OFF : OP_DISPLAY_ON);
          4:  push_op(OP_COM_DIR_FIRST + 8'($urandom_range(0, 15)));
          5:  push_op(OP_PAGE_FIRST + 8'($urandom_range(0, 15)));
          6:  push_op(OP_COL_LO_FIRST + 8'($urandom_range(0, 15)));
          7:  push_op(OP_COL_HI_FIRST + 8'($urandom_range(0, 7)));
          8: begin
            // favour mux ratios that make most rows visible
            case ($urandom_range(0, 3))
              0:       push_with_arg(OP_MUX_RATIO, 8'd63);
              1:       push_with_arg(OP_MUX_RATIO, 8'd127);
              default: push_with_arg(OP_MUX_RATIO, 8'($urandom_range(0, 255)));
            endcase
          end
          9:  push_with_arg(OP_ROW_OFFSET, 8'($urandom_range(0, 255)));
          10: push_with_arg(OP_START_LINE, 8'($urandom_range(0, 255)));
          default: begin
            case ($urandom_range(0, 4))
              0:       push_with_arg(OP_CONTRAST, 8'($urandom_range(0, 255)));
              1:       push_with_arg(OP_CLOCK_DIV, 8'($urandom_range(0, 255)));
              2:       push_with_arg(OP_PRECHARGE, 8'($urandom_range(0, 255)));
              3:       push_with_arg(OP_DCDC, 8'($urandom_range(0, 255)));
              default: push_with_arg(OP_VCOM, 8'($urandom_range(0, 255)));
            endcase
          end
        endcase
      end else if (sel < 95) begin
        push_op(8'($urandom_range(0, 255)));
      end else begin
        push_word(KIND_NONE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned h;
    int unsigned cs;
    int unsigned ce;
    int unsigned ps;
    int unsigned pe;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_PANEL_HEIGHT;
    cfg_wdata_i <= 8'h00;

    // shadow state after reset
    for (int i = 0; i < RAM_WORDS; i++) shadow_ram[i] = 8'h00;
    shadow_cfg       = '{8'd64, 7'd0, 7'd0, 7'd0, 7'd127, 4'd0, 4'd7};
    shadow_ctl       = '0;
    shadow_ctl.mux_ratio = 8'd15;
    shadow_col       = '0;
    shadow_page      = '0;
    shadow_page_mode = 1'b1;
    held_op          = OP_NONE;
    op_held          = 1'b0;
    queued_cnt       = 0;
    result_cnt       = 0;
    fault_cnt        = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      // panel and window settings, extremes first, then random ones
      case (p)
        0: program_panel(64, 0, 0, 0, 127, 0, 7);
        1: program_panel(128, 127, 127, 127, 127, 15, 15);
        2: program_panel(0, 0, 0, 0, 0, 0, 0);  // zero height: no row wrap
        default: begin
          case ($urandom_range(0, 2))
            0:       h = 64;
            1:       h = 128;
            default: h = $urandom_range(64, 128);
          endcase
          cs = $urandom_range(0, 127);
          ps = $urandom_range(0, 15);
          // last phase lets the window start sit past its end
          ce = (p == PHASES - 1) ? $urandom_range(0, 127) : $urandom_range(cs, 127);
          pe = (p == PHASES - 1) ? $urandom_range(0, 15) : $urandom_range(ps, 15);
          program_panel(h, $urandom_range(0, 127), $urandom_range(0, 127), cs, ce, ps, pe);
        end
      endcase

      if (p == 0) begin
        // directed opening; panel still off, mux ratio at its reset value
        push_word(KIND_SCAN, 8'h00, 7'd0, 7'd0);        // panel off: dark
        push_word(KIND_NONE, 8'hFF, 7'h7F, 7'h7F);     // unused kind: all zero
        push_op(OP_DISPLAY_ON);
        push_word(KIND_DATA, 8'hFF, 7'h00, 7'h7F);
        push_word(KIND_DATA, 8'h00, 7'h7F, 7'h00);
        push_word(KIND_DATA, OP_ALL_ON, 7'h55, 7'h2A);  // data that looks like a command
        push_with_arg(OP_MUX_RATIO, 8'h7F);
        push_word(KIND_SCAN, 8'h00, 7'h7F, 7'h7F);     // lands on the 0xFF byte
        push_word(KIND_SCAN, 8'hFF, 7'h00, 7'h00);     // wraps past panel height
        push_op(OP_INVERSE);
        push_word(KIND_SCAN, 8'h00, 7'h7E, 7'h7F);     // unlit byte shows lit
        push_op(OP_ALL_ON);
        push_word(KIND_SCAN, 8'h00, 7'h40, 7'h10);
        push_op(OP_ALL_ON_OFF);
        push_op(OP_NORMAL);
        // argument held across a data and a scan word, then swallowed
        push_op(OP_CLOCK_DIV);
        push_word(KIND_DATA, 8'h3C, 7'h01, 7'h02);
        push_word(KIND_SCAN, 8'h00, 7'h7D, 7'h7F);
        push_op(OP_MUX_RATIO);
        push_op(8'hFF);                                  // unknown command
        push_op(OP_REMAP_ON);
        push_op(OP_COM_DIR_LAST);
        push_with_arg(OP_ROW_OFFSET, 8'hFF);
        push_with_arg(OP_START_LINE, 8'h80);
        push_op(OP_MODE_COLUMN);
        push_op(OP_PAGE_LAST);
        push_op(OP_COL_LO_LAST);
        push_op(OP_COL_HI_LAST);
        push_word(KIND_DATA, 8'h81, 7'h00, 7'h00);     // page past the window end
        push_op(OP_DISPLAY_OFF);
        push_word(KIND_SCAN, 8'h00, 7'h00, 7'h7F);
        push_op(OP_DISPLAY_ON);
      end
      push_random_traffic(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0 && pixel_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
sv/oledc_pkg.sv
sv/oledc_in_if.sv
sv/oledc_out_if.sv
sv/oledc_ram.sv
sv/oledc_regs.sv
sv/oled_controller_ram_and_scan.sv
sv/oledc_checker.sv
bench/oled_controller_ram_and_scan_tb.sv
